// ===== design/spf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Types and constants shared by the serial packet framer modules.
// ----------------------------------------------------------------------------
package spf_pkg;

    // Queue depths (powers of two so that the pointers wrap on their own).
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] MARK_SYNC      = 8'hFF;
    localparam logic [7:0] MARK_START     = 8'h55;
    localparam logic [7:0] LINGO_ID       = 8'h00;
    localparam logic [7:0] AUTH_VER_MAJOR = 8'h02;
    localparam logic [7:0] AUTH_VER_MINOR = 8'h00;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [1:0] EXTRA_NONE    = 2'd0;
    localparam logic [1:0] EXTRA_AUTH    = 2'd1;
    localparam logic [1:0] EXTRA_SESSION = 2'd2;

    // Byte sequencer steps.
    localparam logic [3:0] STEP_FIRST  = 4'd0;
    localparam logic [3:0] STEP_START  = 4'd1;
    localparam logic [3:0] STEP_LEN    = 4'd2;
    localparam logic [3:0] STEP_LINGO  = 4'd3;
    localparam logic [3:0] STEP_CMD    = 4'd4;
    localparam logic [3:0] STEP_TID_HI = 4'd5;
    localparam logic [3:0] STEP_TID_LO = 4'd6;
    localparam logic [3:0] STEP_EXTRA0 = 4'd7;
    localparam logic [3:0] STEP_EXTRA1 = 4'd8;
    localparam logic [3:0] STEP_EXTRA2 = 4'd9;
    localparam logic [3:0] STEP_EXTRA3 = 4'd10;
    localparam logic [3:0] STEP_CSUM   = 4'd15;

    typedef struct packed {
        logic        is_header;
        logic [7:0]  len;
        logic [7:0]  cid;
        logic [15:0] tid;
        logic [1:0]  extra;
        logic [7:0]  page_now;
        logic [7:0]  page_max;
        logic [15:0] sid;
        logic        has_payload;
        logic [7:0]  pbyte;
        logic        last;
    } desc_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       packet_end;
    } res_t;

endpackage
`default_nettype wire

// ===== design/spf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_front
// Accepts input items, tracks the open packet and the own transaction ID,
// and turns each useful item into a descriptor for the byte sequencer.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic [7:0]  packet_length,
    input  wire logic [7:0]  command_id,
    input  wire logic        id_rule,
    input  wire logic [15:0] host_tid,
    input  wire logic [1:0]  header_extra,
    input  wire logic [7:0]  page_now,
    input  wire logic [7:0]  page_max,
    input  wire logic [15:0] session_id,
    input  wire logic        has_payload,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        last,
    output logic             cq_push,
    output desc_t            cq_desc,
    input  wire logic        cq_full
);

    logic [15:0] own_tid_reg, own_tid_next;
    logic        in_packet_reg, in_packet_next;
    logic        accept;

    assign full   = cq_full;
    assign accept = push && !cq_full;

    always_comb
    begin
        own_tid_next   = own_tid_reg;
        in_packet_next = in_packet_reg;
        cq_push        = 1'b0;

        cq_desc.is_header   = (cmd == CMD_START);
        cq_desc.len         = packet_length;
        cq_desc.cid         = command_id;
        cq_desc.tid         = id_rule ? own_tid_reg + 16'd1 : host_tid;
        cq_desc.extra       = header_extra;
        cq_desc.page_now    = page_now;
        cq_desc.page_max    = page_max;
        cq_desc.sid         = session_id;
        cq_desc.has_payload = has_payload;
        cq_desc.pbyte       = payload_byte;
        cq_desc.last        = last;

        if (accept)
        begin
            if (cmd == CMD_START)
            begin
                cq_push        = 1'b1;
                in_packet_next = has_payload;
                if (id_rule)
                begin
                    own_tid_next = own_tid_reg + 16'd1;
                end
            end
            else if (in_packet_reg)
            begin
                // Payload outside a packet is dropped here and never queued.
                cq_push = 1'b1;
                if (last)
                begin
                    in_packet_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_tid_reg   <= '0;
            in_packet_reg <= 1'b0;
        end
        else
        begin
            own_tid_reg   <= own_tid_next;
            in_packet_reg <= in_packet_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/spf_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_cmd_queue
// Short descriptor queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module spf_cmd_queue
    import spf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr,
    input  desc_t      wr_desc,
    output logic       full,
    input  wire logic  rd,
    output desc_t      rd_desc,
    output logic       empty
);

    desc_t            mem_reg [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CQ_CW-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CQ_CW'(CQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/spf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_back
// Byte sequencer: walks each descriptor one byte per cycle while the result
// queue has room, keeps the running checksum and feeds the result queue.
// ----------------------------------------------------------------------------
module spf_back
    import spf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  desc_t      cq_desc,
    input  wire logic  cq_empty,
    output logic       cq_pop,
    input  wire logic  pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       packet_end
);

    logic [3:0]       step_reg, step_next;
    logic [7:0]       sum_reg, sum_next;
    res_t             oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [OQ_CW-1:0] oq_count_reg;
    logic             oq_full, oq_pop;
    logic             fire, summed, final_byte;
    logic [3:0]       last_data;
    res_t             res;

    assign oq_full = (oq_count_reg == OQ_CW'(OQ_DEPTH));
    assign empty   = (oq_count_reg == '0);
    assign oq_pop  = pop && !empty;
    assign fire    = !cq_empty && !oq_full;
    assign cq_pop  = fire && final_byte;

    always_comb
    begin
        case (cq_desc.extra)
            EXTRA_AUTH:    last_data = STEP_EXTRA3;
            EXTRA_SESSION: last_data = STEP_EXTRA1;
            default:       last_data = STEP_TID_LO;
        endcase

        res.data       = 8'h00;
        res.packet_end = 1'b0;
        summed         = 1'b1;
        step_next      = step_reg;

        if (step_reg == STEP_CSUM)
        begin
            res.data       = 8'h00 - sum_reg;
            res.packet_end = 1'b1;
            summed         = 1'b0;
            final_byte     = 1'b1;
            step_next      = STEP_FIRST;
        end
        else if (cq_desc.is_header)
        begin
            case (step_reg)
                STEP_FIRST:  res.data = MARK_SYNC;
                STEP_START:  res.data = MARK_START;
                STEP_LEN:    res.data = cq_desc.len;
                STEP_LINGO:  res.data = LINGO_ID;
                STEP_CMD:    res.data = cq_desc.cid;
                STEP_TID_HI: res.data = cq_desc.tid[15:8];
                STEP_TID_LO: res.data = cq_desc.tid[7:0];
                STEP_EXTRA0: res.data = (cq_desc.extra == EXTRA_AUTH) ?
                                        AUTH_VER_MAJOR : cq_desc.sid[15:8];
                STEP_EXTRA1: res.data = (cq_desc.extra == EXTRA_AUTH) ?
                                        AUTH_VER_MINOR : cq_desc.sid[7:0];
                STEP_EXTRA2: res.data = cq_desc.page_now;
                STEP_EXTRA3: res.data = cq_desc.page_max;
                default:     res.data = 8'h00;
            endcase
            // The two marker bytes stay out of the checksum.
            summed = !(step_reg inside {STEP_FIRST, STEP_START});
            if (step_reg == last_data)
            begin
                final_byte = cq_desc.has_payload;
                step_next  = cq_desc.has_payload ? STEP_FIRST : STEP_CSUM;
            end
            else
            begin
                final_byte = 1'b0;
                step_next  = step_reg + 4'd1;
            end
        end
        else
        begin
            res.data   = cq_desc.pbyte;
            final_byte = !cq_desc.last;
            step_next  = cq_desc.last ? STEP_CSUM : STEP_FIRST;
        end

        res.run_last = final_byte;

        sum_next = sum_reg;
        if (cq_desc.is_header && step_reg == STEP_FIRST)
        begin
            sum_next = 8'h00;
        end
        else if (summed)
        begin
            sum_next = sum_reg + res.data;
        end
    end

    assign out_byte   = oq_reg[oq_rd_ptr_reg].data;
    assign run_last   = oq_reg[oq_rd_ptr_reg].run_last;
    assign packet_end = oq_reg[oq_rd_ptr_reg].packet_end;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            oq_reg[oq_wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            sum_reg       <= '0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                step_reg      <= step_next;
                sum_reg       <= sum_next;
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
            if (fire && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + 1'b1;
            end
            else if (oq_pop && !fire)
            begin
                oq_count_reg <= oq_count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/serial_packet_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_packet_framer
// Builds outgoing serial packets (header, payload, checksum) byte by byte.
// ----------------------------------------------------------------------------
// An item is taken in any cycle in which the two-entry descriptor queue has
// room, so items may arrive back to back. The byte sequencer behind it emits
// one result per cycle into a four-entry result queue while that queue has
// room: a start item yields 7 to 12 bytes, a payload item one or two, and a
// payload item outside an open packet yields none and is dropped. With results
// popped every cycle the sustained rate is one payload item per cycle; header
// bursts and checksum bytes fill the queues and push back through full.
module serial_packet_framer
    import spf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic [7:0]  packet_length,
    input  wire logic [7:0]  command_id,
    input  wire logic        id_rule,
    input  wire logic [15:0] host_tid,
    input  wire logic [1:0]  header_extra,
    input  wire logic [7:0]  page_now,
    input  wire logic [7:0]  page_max,
    input  wire logic [15:0] session_id,
    input  wire logic        has_payload,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             packet_end
);

    logic  cq_push, cq_full, cq_pop, cq_empty;
    desc_t cq_wr_desc, cq_rd_desc;

    spf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .packet_length (packet_length),
        .command_id    (command_id),
        .id_rule       (id_rule),
        .host_tid      (host_tid),
        .header_extra  (header_extra),
        .page_now      (page_now),
        .page_max      (page_max),
        .session_id    (session_id),
        .has_payload   (has_payload),
        .payload_byte  (payload_byte),
        .last          (last),
        .cq_push       (cq_push),
        .cq_desc       (cq_wr_desc),
        .cq_full       (cq_full)
    );

    spf_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cq_push),
        .wr_desc (cq_wr_desc),
        .full    (cq_full),
        .rd      (cq_pop),
        .rd_desc (cq_rd_desc),
        .empty   (cq_empty)
    );

    spf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cq_desc    (cq_rd_desc),
        .cq_empty   (cq_empty),
        .cq_pop     (cq_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .packet_end (packet_end)
    );

endmodule
`default_nettype wire

// ===== tb/sv/spf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_checker
// Watches both queue interfaces of the serial packet framer, predicts the
// packet bytes that each accepted item must produce and compares every popped
// byte with the oldest prediction.
// ----------------------------------------------------------------------------
module spf_checker
    import spf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        cmd,
    input  wire logic [7:0]  packet_length,
    input  wire logic [7:0]  command_id,
    input  wire logic        id_rule,
    input  wire logic [15:0] host_tid,
    input  wire logic [1:0]  header_extra,
    input  wire logic [7:0]  page_now,
    input  wire logic [7:0]  page_max,
    input  wire logic [15:0] session_id,
    input  wire logic        has_payload,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        last,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [7:0]  out_byte,
    input  wire logic        run_last,
    input  wire logic        packet_end,
    output int               errors,
    output int               awaited
);

    res_t        expected_bytes[$];
    logic [15:0] tid_count;
    logic [7:0]  csum_acc;
    logic        packet_open;
    int          error_count = 0;

    assign errors = error_count;

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        error_count = error_count + 1;
        $display("%0t ns  %s: got %02h, expected %02h", $realtime, what, got, want);
    endtask

    task automatic emit(input logic [7:0] b, input logic summed, input logic is_csum);
        res_t r;
        r.data       = b;
        r.run_last   = 1'b0;
        r.packet_end = is_csum;
        expected_bytes.push_back(r);
        if (summed)
            csum_acc = csum_acc + b;
    endtask

    task automatic frame_item();
        logic [15:0] tid;
        int          first;
        res_t        r;
        first = expected_bytes.size();
        if (cmd == CMD_START) begin
            if (id_rule) begin
                tid_count = tid_count + 16'd1;
                tid = tid_count;
            end
            else begin
                tid = host_tid;
            end
            // A start always opens a fresh sum; an open packet is simply dropped.
            csum_acc = 8'h00;
            emit(MARK_SYNC, 1'b0, 1'b0);
            emit(MARK_START, 1'b0, 1'b0);
            emit(packet_length, 1'b1, 1'b0);
            emit(LINGO_ID, 1'b1, 1'b0);
            emit(command_id, 1'b1, 1'b0);
            emit(tid[15:8], 1'b1, 1'b0);
            emit(tid[7:0], 1'b1, 1'b0);
            if (header_extra == EXTRA_AUTH) begin
                emit(AUTH_VER_MAJOR, 1'b1, 1'b0);
                emit(AUTH_VER_MINOR, 1'b1, 1'b0);
                emit(page_now, 1'b1, 1'b0);
                emit(page_max, 1'b1, 1'b0);
            end
            else if (header_extra == EXTRA_SESSION) begin
                emit(session_id[15:8], 1'b1, 1'b0);
                emit(session_id[7:0], 1'b1, 1'b0);
            end
            if (has_payload) begin
                packet_open = 1'b1;
            end
            else begin
                emit(8'h00 - csum_acc, 1'b0, 1'b1);
                packet_open = 1'b0;
            end
        end
        else if (packet_open) begin
            emit(payload_byte, 1'b1, 1'b0);
            if (last) begin
                emit(8'h00 - csum_acc, 1'b0, 1'b1);
                packet_open = 1'b0;
            end
        end
        if (expected_bytes.size() > first) begin
            r = expected_bytes.pop_back();
            r.run_last = 1'b1;
            expected_bytes.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n) begin
            tid_count   = 16'h0000;
            csum_acc    = 8'h00;
            packet_open = 1'b0;
            expected_bytes.delete();
        end
        else begin
            // Compare first: a byte on the ports now belongs to an older item.
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    report("unexpected byte", out_byte, 8'h00);
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                        report("out_byte", out_byte, want.data);
                    if (run_last !== want.run_last)
                        report("run_last", {7'd0, run_last}, {7'd0, want.run_last});
                    if (packet_end !== want.packet_end)
                        report("packet_end", {7'd0, packet_end}, {7'd0, want.packet_end});
                end
            end
            if (push && !full)
                frame_item();
        end
        awaited = expected_bytes.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the serial packet framer: a directed set of packets, then
// random well-formed packets with some noise, under several idling mixes on
// the input and result queues.
// ----------------------------------------------------------------------------
module tb
    import spf_pkg::*;
;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  len;
        logic [7:0]  cid;
        logic        id_rule;
        logic [15:0] host;
        logic [1:0]  extra;
        logic [7:0]  pnow;
        logic [7:0]  pmax;
        logic [15:0] sid;
        logic        has_pl;
        logic [7:0]  pbyte;
        logic        last;
    } frame_in_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        cmd = 1'b0;
    logic [7:0]  packet_length = 8'h00;
    logic [7:0]  command_id = 8'h00;
    logic        id_rule = 1'b0;
    logic [15:0] host_tid = 16'h0000;
    logic [1:0]  header_extra = 2'd0;
    logic [7:0]  page_now = 8'h00;
    logic [7:0]  page_max = 8'h00;
    logic [15:0] session_id = 16'h0000;
    logic        has_payload = 1'b0;
    logic [7:0]  payload_byte = 8'h00;
    logic        last = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        packet_end;
    int          errors;
    int          awaited;

    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          counted = 0;
    logic        open_pkt = 1'b0;

    always #5 clk = ~clk;

    serial_packet_framer uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .cmd(cmd), .packet_length(packet_length), .command_id(command_id),
        .id_rule(id_rule), .host_tid(host_tid), .header_extra(header_extra),
        .page_now(page_now), .page_max(page_max), .session_id(session_id),
        .has_payload(has_payload), .payload_byte(payload_byte), .last(last),
        .empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
        .packet_end(packet_end)
    );

    spf_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .cmd(cmd), .packet_length(packet_length), .command_id(command_id),
        .id_rule(id_rule), .host_tid(host_tid), .header_extra(header_extra),
        .page_now(page_now), .page_max(page_max), .session_id(session_id),
        .has_payload(has_payload), .payload_byte(payload_byte), .last(last),
        .empty(empty), .pop(pop), .out_byte(out_byte), .run_last(run_last),
        .packet_end(packet_end), .errors(errors), .awaited(awaited)
    );

    always @(negedge clk)
    begin
        pop = rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    function automatic frame_in_t random_fields();
        frame_in_t it;
        it.cmd     = 1'($urandom_range(1));
        it.len     = 8'($urandom);
        it.cid     = 8'($urandom);
        it.id_rule = 1'($urandom_range(1));
        it.host    = 16'($urandom);
        it.extra   = 2'($urandom_range(3));
        it.pnow    = 8'($urandom);
        it.pmax    = 8'($urandom);
        it.sid     = 16'($urandom);
        it.has_pl  = 1'($urandom_range(1));
        it.pbyte   = 8'($urandom);
        it.last    = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic frame_in_t start_item(input logic [7:0] len, input logic [7:0] cid,
                                             input logic rule, input logic [15:0] host,
                                             input logic [1:0] extra, input logic [7:0] pnow,
                                             input logic [7:0] pmax, input logic [15:0] sid,
                                             input logic has_pl);
        frame_in_t it;
        it         = random_fields();
        it.cmd     = CMD_START;
        it.len     = len;
        it.cid     = cid;
        it.id_rule = rule;
        it.host    = host;
        it.extra   = extra;
        it.pnow    = pnow;
        it.pmax    = pmax;
        it.sid     = sid;
        it.has_pl  = has_pl;
        return it;
    endfunction

    function automatic frame_in_t payload_item(input logic [7:0] b, input logic is_last);
        frame_in_t it;
        it       = random_fields();
        it.cmd   = CMD_PAYLOAD;
        it.pbyte = b;
        it.last  = is_last;
        return it;
    endfunction

    task automatic send_item(input frame_in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            push = 1'b0;
        end
        @(negedge clk);
        push          = 1'b1;
        cmd           = it.cmd;
        packet_length = it.len;
        command_id    = it.cid;
        id_rule       = it.id_rule;
        host_tid      = it.host;
        header_extra  = it.extra;
        page_now      = it.pnow;
        page_max      = it.pmax;
        session_id    = it.sid;
        has_payload   = it.has_pl;
        payload_byte  = it.pbyte;
        last          = it.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // Track the open packet so that ignored items are not counted.
        if (it.cmd == CMD_START) begin
            open_pkt = it.has_pl;
            counted++;
        end
        else if (open_pkt) begin
            if (it.last)
                open_pkt = 1'b0;
            counted++;
        end
    endtask

    task automatic random_packet();
        frame_in_t it;
        int        n;
        it        = random_fields();
        it.cmd    = CMD_START;
        it.has_pl = ($urandom_range(9) != 0);
        send_item(it);
        if (it.has_pl) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
                // Now and then the final byte is left unmarked, so the next
                // start abandons the packet.
                send_item(payload_item(8'($urandom),
                                       (k == n - 1) && ($urandom_range(9) != 0)));
            end
        end
        if (!open_pkt && $urandom_range(7) == 0)
            send_item(payload_item(8'($urandom), 1'($urandom_range(1))));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (awaited != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed packets.
        send_item(start_item(8'h00, 8'h00, 1'b1, 16'h0000, EXTRA_NONE,
                             8'h00, 8'h00, 16'h0000, 1'b0));
        send_item(start_item(8'hFF, 8'hFF, 1'b0, 16'hFFFF, EXTRA_AUTH,
                             8'hFF, 8'h00, 16'h0000, 1'b1));
        send_item(payload_item(8'h00, 1'b0));
        send_item(payload_item(8'hFF, 1'b0));
        send_item(payload_item(8'h80, 1'b1));
        send_item(payload_item(8'h5A, 1'b1));
        send_item(start_item(8'h10, 8'h42, 1'b1, 16'h1234, EXTRA_SESSION,
                             8'h00, 8'h00, 16'hA5C3, 1'b1));
        send_item(payload_item(8'h12, 1'b0));
        // A new start while a packet is open, with the unused extra selector.
        send_item(start_item(8'h80, 8'h01, 1'b1, 16'h0000, 2'd3,
                             8'hFF, 8'hFF, 16'hFFFF, 1'b0));
        send_item(start_item(8'h01, 8'h80, 1'b0, 16'h0000, EXTRA_AUTH,
                             8'h00, 8'hFF, 16'h0000, 1'b1));
        send_item(payload_item(8'h00, 1'b1));
        send_item(start_item(8'h7F, 8'hC3, 1'b0, 16'h8000, EXTRA_SESSION,
                             8'h00, 8'h00, 16'hFFFF, 1'b0));
        send_item(start_item(8'h05, 8'h3C, 1'b0, 16'h00FF, EXTRA_SESSION,
                             8'h00, 8'h00, 16'h0000, 1'b1));
        send_item(payload_item(8'hFF, 1'b1));
        wait_drained();

        send_idle_pct = 0;
        pop_stall_pct = 0;
        while (counted < 85)
            random_packet();
        send_idle_pct = 85;
        while (counted < 155)
            random_packet();
        wait_drained();
        send_idle_pct = 0;
        pop_stall_pct = 85;
        while (counted < 225)
            random_packet();
        send_idle_pct = 6;
        pop_stall_pct = 6;
        while (counted < 275)
            random_packet();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        while (counted < 300)
            random_packet();

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && awaited == 0)
            $display("[serial_packet_framer] OK");
        else
            $display("[serial_packet_framer] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[serial_packet_framer] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/spf_pkg.sv
design/spf_front.sv
design/spf_cmd_queue.sv
design/spf_back.sv
design/serial_packet_framer.sv
tb/sv/spf_checker.sv
tb/sv/tb.sv
